// ----- rtl/srt_pkg.sv -----
// shared types and codes of the sorted record table
package srt_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int RANK_W = 5;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_POP    = 2'd3;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [30:0] item_id;
      logic [19:0] postal_key;
      logic [15:0] house_number;
      logic [15:0] apartment_number;
      logic [31:0] mass_bits;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [RANK_W-1:0] rank;
      logic [30:0]       out_id;
      logic [19:0]       out_key;
      logic [15:0]       out_house;
      logic [15:0]       out_apartment;
      logic [31:0]       out_mass;
   } rsp_type;

   typedef struct packed {
      logic [19:0] key;
      logic [30:0] id;
      logic [15:0] house;
      logic [15:0] apartment;
      logic [31:0] mass;
   } record_type;

   typedef struct packed {
      logic       insert_en;
      logic       match_en;
      logic       by_pop;
      logic       remove_en;
      logic [30:0] search_id;
      record_type new_rec;
   } cell_ctrl_type;

endpackage

// ----- rtl/srt_cell.sv -----
// one slot of the table: holds a record, compares and shifts with its neighbors
module srt_cell #(
   parameter bit IS_HEAD = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  srt_pkg::record_type   left_rec,
   input  logic                  left_keep,
   input  srt_pkg::record_type   right_rec,
   input  logic                  seen_in,
   output srt_pkg::record_type   rec,
   output logic                  keep,
   output logic                  seen_out,
   output logic                  hit
);
   import srt_pkg::*;

   record_type rec_ff;
   logic       match_ff;
   logic       id_eq;

   assign id_eq    = (rec_ff.id == ctrl.search_id);
   assign keep     = occupied &&
                     ({rec_ff.key, rec_ff.id} <= {ctrl.new_rec.key, ctrl.new_rec.id});
   assign seen_out = seen_in | match_ff;
   assign hit      = match_ff & ~seen_in;
   assign rec      = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctrl.match_en) begin
         match_ff <= occupied && (ctrl.by_pop ? IS_HEAD : id_eq);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert_en && !keep) begin
         rec_ff <= left_keep ? ctrl.new_rec : left_rec;
      end else if (ctrl.remove_en && (seen_in || match_ff)) begin
         rec_ff <= right_rec;
      end
   end

endmodule

// ----- rtl/sorted_record_table_unit.sv -----
// sorted record table: a chain of record cells kept in key then id order
// insert: result strobe registered at the accepting edge; the unit stays idle, ready for the next command
// delete, find, pop: the accepting edge enters the search state, whose end registers the strobe
// one insert per cycle while not busy; other commands hold busy until their result strobe
// the id search ripples a first-match flag along the chain of cells
// synchronous reset empties the table; results cannot be stalled
module sorted_record_table_unit #(
   parameter int CAPACITY = srt_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   output srt_pkg::rsp_type rsp_data
);
   import srt_pkg::*;

   localparam int FILL_W = $clog2(CAPACITY + 1);

   typedef enum logic {ST_IDLE, ST_ACT} state_type;

   state_type        state_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [1:0]       cmd_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   cell_ctrl_type    ctrl;
   record_type       cell_rec [CAPACITY];
   logic [CAPACITY-1:0] keep_vec;
   logic [CAPACITY-1:0] seen_vec;
   logic [CAPACITY-1:0] hit_vec;
   logic [CAPACITY-1:0] occ_vec;

   record_type        gather_rec;
   logic [RANK_W-1:0] gather_rank;
   logic              any_hit;
   logic              full;
   logic              accept;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign full      = (fill_ff == FILL_W'(CAPACITY));
   assign any_hit   = |hit_vec;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ctrl.insert_en  = accept && (req_data.cmd == CMD_INSERT) && !full;
      ctrl.match_en   = accept && (req_data.cmd != CMD_INSERT);
      ctrl.by_pop     = (req_data.cmd == CMD_POP);
      ctrl.remove_en  = (state_ff == ST_ACT) && any_hit &&
                        ((cmd_ff == CMD_DELETE) || (cmd_ff == CMD_POP));
      ctrl.search_id  = req_data.item_id;
      ctrl.new_rec.key       = req_data.postal_key;
      ctrl.new_rec.id        = req_data.item_id;
      ctrl.new_rec.house     = req_data.house_number;
      ctrl.new_rec.apartment = req_data.apartment_number;
      ctrl.new_rec.mass      = req_data.mass_bits;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic       left_keep;
      logic       seen_in;
      record_type left_rec;
      record_type right_rec;

      assign occ_vec[i] = (fill_ff > FILL_W'(i));

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign seen_in   = 1'b0;
         assign left_rec  = ctrl.new_rec;
      end else begin : g_body
         assign left_keep = keep_vec[i-1];
         assign seen_in   = seen_vec[i-1];
         assign left_rec  = cell_rec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_rec = cell_rec[i];
      end else begin : g_mid
         assign right_rec = cell_rec[i+1];
      end

      srt_cell #(
         .IS_HEAD (i == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .occupied  (occ_vec[i]),
         .left_rec  (left_rec),
         .left_keep (left_keep),
         .right_rec (right_rec),
         .seen_in   (seen_in),
         .rec       (cell_rec[i]),
         .keep      (keep_vec[i]),
         .seen_out  (seen_vec[i]),
         .hit       (hit_vec[i])
      );
   end

   // the hit vector has at most one bit set, so an and-or gathers the matching slot
   always_comb begin
      gather_rec  = '0;
      gather_rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_vec[i]) begin
            gather_rec  = gather_rec | cell_rec[i];
            gather_rank = gather_rank | RANK_W'(i + 1);
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (state_ff == ST_ACT) begin
         if (any_hit) begin
            rsp_data_in.status = STATUS_DONE;
            if (cmd_ff != CMD_DELETE) begin
               rsp_data_in.out_id        = gather_rec.id;
               rsp_data_in.out_key       = gather_rec.key;
               rsp_data_in.out_house     = gather_rec.house;
               rsp_data_in.out_apartment = gather_rec.apartment;
               rsp_data_in.out_mass      = gather_rec.mass;
            end
            if (cmd_ff == CMD_FIND) begin
               rsp_data_in.rank = gather_rank;
            end
         end else begin
            rsp_data_in.status = STATUS_NOTFOUND;
         end
      end else begin
         rsp_data_in.status = full ? STATUS_FULL : STATUS_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff <= req_data.cmd;
                  if (req_data.cmd == CMD_INSERT) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= rsp_data_in;
                     if (!full) begin
                        fill_ff <= fill_ff + FILL_W'(1);
                     end
                  end else begin
                     state_ff <= ST_ACT;
                  end
               end
            end
            ST_ACT: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= rsp_data_in;
               if (any_hit && ((cmd_ff == CMD_DELETE) || (cmd_ff == CMD_POP))) begin
                  fill_ff <= fill_ff - FILL_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACT) |-> $onehot0(hit_vec))
      else $error("more than one slot hit");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_act_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACT) |=> rsp_valid_ff)
      else $error("search command gave no result");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == STATUS_FULL)) |-> full)
      else $error("full status while table has room");
`endif

endmodule

// ----- test/tb_sorted_record_table_unit.sv -----
// self-checking testbench of the sorted record table unit
module tb_sorted_record_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import srt_pkg::*;

   localparam int CAPACITY = CAPACITY_DEFAULT;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   record_type  shadow_rec [CAPACITY];
   int          shadow_count = 0;
   rsp_type     expected_results [$];
   int unsigned mismatch_count = 0;
   int unsigned idle_pct = 0;

   sorted_record_table_unit #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic rsp_type predict_table_result(input req_type r);
      rsp_type    res;
      record_type rec;
      int         pos;
      int         i;
      res = '0;
      case (r.cmd)
         CMD_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               rec.key       = r.postal_key;
               rec.id        = r.item_id;
               rec.house     = r.house_number;
               rec.apartment = r.apartment_number;
               rec.mass      = r.mass_bits;
               pos = 0;
               while (pos < shadow_count &&
                      {shadow_rec[pos].key, shadow_rec[pos].id} <= {rec.key, rec.id})
                  pos++;
               for (i = shadow_count; i > pos; i--)
                  shadow_rec[i] = shadow_rec[i-1];
               shadow_rec[pos] = rec;
               shadow_count++;
               res.status = STATUS_DONE;
            end
         end
         CMD_DELETE, CMD_FIND: begin
            pos = 0;
            while (pos < shadow_count && shadow_rec[pos].id != r.item_id)
               pos++;
            if (pos >= shadow_count) begin
               res.status = STATUS_NOTFOUND;
            end else if (r.cmd == CMD_FIND) begin
               res.status        = STATUS_DONE;
               res.rank          = RANK_W'(pos + 1);
               res.out_id        = shadow_rec[pos].id;
               res.out_key       = shadow_rec[pos].key;
               res.out_house     = shadow_rec[pos].house;
               res.out_apartment = shadow_rec[pos].apartment;
               res.out_mass      = shadow_rec[pos].mass;
            end else begin
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_rec[i] = shadow_rec[i+1];
               shadow_count--;
               res.status = STATUS_DONE;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               res.status = STATUS_NOTFOUND;
            end else begin
               res.status        = STATUS_DONE;
               res.out_id        = shadow_rec[0].id;
               res.out_key       = shadow_rec[0].key;
               res.out_house     = shadow_rec[0].house;
               res.out_apartment = shadow_rec[0].apartment;
               res.out_mass      = shadow_rec[0].mass;
               for (i = 0; i + 1 < shadow_count; i++)
                  shadow_rec[i] = shadow_rec[i+1];
               shadow_count--;
            end
         end
      endcase
      return res;
   endfunction

   // result checker: one beat per strobe, cannot be held off
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: status %0d id %h", rsp_data.status,
                        rsp_data.out_id);
         end else begin
            exp_rsp = expected_results.pop_front();
            if (rsp_data.status !== exp_rsp.status || rsp_data.rank !== exp_rsp.rank ||
                rsp_data.out_id !== exp_rsp.out_id || rsp_data.out_key !== exp_rsp.out_key ||
                rsp_data.out_house !== exp_rsp.out_house ||
                rsp_data.out_apartment !== exp_rsp.out_apartment ||
                rsp_data.out_mass !== exp_rsp.out_mass) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp: status %0d rank %0d id %h key %0d house %h apt %h mass %h",
                           exp_rsp.status, exp_rsp.rank, exp_rsp.out_id, exp_rsp.out_key,
                           exp_rsp.out_house, exp_rsp.out_apartment, exp_rsp.out_mass);
                  $display("         got: status %0d rank %0d id %h key %0d house %h apt %h mass %h",
                           rsp_data.status, rsp_data.rank, rsp_data.out_id, rsp_data.out_key,
                           rsp_data.out_house, rsp_data.out_apartment, rsp_data.out_mass);
               end
            end
         end
      end
   end

   task automatic send_command(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      expected_results.push_back(predict_table_result(r));
      if ($urandom_range(0, 99) < idle_pct) begin
         start    <= 1'b0;
         req_data <= req_type'({$urandom(), $urandom(), $urandom(), $urandom()});
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do
         @(posedge clock);
      while (expected_results.size() != 0);
   endtask

   function automatic req_type make_insert(input logic [19:0] key, input logic [30:0] id,
                                           input logic [15:0] house, input logic [15:0] apt,
                                           input logic [31:0] mass);
      req_type r;
      r.cmd              = CMD_INSERT;
      r.item_id          = id;
      r.postal_key       = key;
      r.house_number     = house;
      r.apartment_number = apt;
      r.mass_bits        = mass;
      return r;
   endfunction

   function automatic req_type make_lookup(input logic [1:0] cmd, input logic [30:0] id);
      req_type r;
      r         = '0;
      r.cmd     = cmd;
      r.item_id = id;
      return r;
   endfunction

   task automatic test_empty_table();
      send_command(make_lookup(CMD_POP, 31'd0));
      send_command(make_lookup(CMD_DELETE, 31'd5));
      send_command(make_lookup(CMD_FIND, 31'd5));
   endtask

   task automatic test_ordering();
      send_command(make_insert(20'd999999, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
      send_command(make_insert(20'd0, 31'd0, 16'h0000, 16'h0000, 32'h00000000));
      send_command(make_insert(20'd500, 31'd7, 16'h1111, 16'h2222, 32'hAAAA5555));
      // same key and id: goes after the existing one
      send_command(make_insert(20'd500, 31'd7, 16'h3333, 16'h4444, 32'h5555AAAA));
      send_command(make_insert(20'd500, 31'd3, 16'h5A5A, 16'hA5A5, 32'h12345678));
      send_command(make_lookup(CMD_FIND, 31'd7));
      send_command(make_lookup(CMD_DELETE, 31'd7));
      send_command(make_lookup(CMD_FIND, 31'd7));
      send_command(make_lookup(CMD_DELETE, 31'd99));
      send_command(make_lookup(CMD_POP, 31'd0));
   endtask

   task automatic test_full_table();
      int k;
      for (k = 0; k < 13; k++)
         send_command(make_insert(20'(1000 + k), 31'(200 + k), 16'(k), 16'(~k),
                                  $urandom()));
      send_command(make_insert(20'd1, 31'd1, 16'h1234, 16'h5678, 32'hDEADBEEF));
      send_command(make_lookup(CMD_FIND, 31'h7FFFFFFF));
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle);
      req_type     r;
      int unsigned k;
      int unsigned p;
      bit          fill_phase;
      idle_pct = idle;
      for (k = 0; k < count; k++) begin
         fill_phase = ((k / 40) % 2) == 0;
         p = $urandom_range(0, 99);
         r.item_id = $urandom_range(0, 1) ? 31'($urandom_range(0, 15)) : 31'($urandom());
         r.postal_key = $urandom_range(0, 1) ? 20'($urandom_range(0, 3) * 333333)
                                             : 20'($urandom_range(0, 999999));
         r.house_number     = 16'($urandom());
         r.apartment_number = 16'($urandom());
         r.mass_bits        = $urandom();
         if (fill_phase)
            r.cmd = (p < 55) ? CMD_INSERT : (p < 70) ? CMD_DELETE : (p < 90) ? CMD_FIND : CMD_POP;
         else
            r.cmd = (p < 20) ? CMD_INSERT : (p < 45) ? CMD_DELETE : (p < 75) ? CMD_FIND : CMD_POP;
         // mostly search for ids that are present
         if ((r.cmd == CMD_DELETE || r.cmd == CMD_FIND) && shadow_count > 0 &&
             $urandom_range(0, 3) != 0)
            r.item_id = shadow_rec[$urandom_range(0, shadow_count - 1)].id;
         send_command(r);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_ordering();
      test_full_table();
      wait_for_drain();
      test_random_traffic(600, 0);
      wait_for_drain();
      test_random_traffic(600, 70);
      wait_for_drain();
      test_random_traffic(600, 30);
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
